// ===== rtl/core/scr_pkg.sv =====
// Package for the slice cost registry: widths, action codes, entry layout.
// No dependencies.
package scr_pkg;

  localparam int KEY_ENTRIES_DEF = 64;
  localparam int KEY_W = 6;

  localparam logic [40:0] AVG_ONE = 41'h1_0000_0000;
  localparam logic [40:0] AVG_MAX = 41'h100_0000_0000;
  localparam logic [35:0] SAMPLE_MAX = 36'h8_0000_0000;

  typedef enum logic [2:0] {
    ACT_SEED     = 3'd0,
    ACT_SLICE    = 3'd1,
    ACT_DEFERRAL = 3'd2,
    ACT_CLEAR    = 3'd3,
    ACT_READ     = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_PREP,
    ST_MUL,
    ST_AVG,
    ST_WRITE,
    ST_CLEAR,
    ST_OUT
  } state_t;

  // Measurement part of one entry (cleared by reset_measurements).
  typedef struct packed {
    logic [32:0] last_slice;
    logic [31:0] worst;
    logic [31:0] second;
    logic [47:0] sum;
    logic [31:0] slices;
    logic [31:0] deferrals;
    logic [31:0] escapes;
  } stats_t;

  // Learned part of one entry (kept across reset_measurements).
  typedef struct packed {
    logic [40:0] avg;
    logic [24:0] last_seed;
    logic [31:0] seeded;
  } learn_t;

  localparam stats_t STATS_RESET = '{last_slice: {33{1'b1}}, worst: '0, second: '0,
                                     sum: '0, slices: '0, deferrals: '0, escapes: '0};
  localparam learn_t LEARN_RESET = '{avg: AVG_ONE, last_seed: '0, seeded: '0};

  typedef struct packed {
    logic [24:0] seed_scale;
    logic [24:0] scale_whole;
    stats_t      st;
    logic [31:0] seeded;
  } result_t;

endpackage

// ===== rtl/core/slice_cost_registry_top.sv =====
// Slice cost registry top level: two entry memories, sequencer, serial divider.
// Depends on scr_pkg.
//
//  channel | dir | beat contents
//  s_axis  | in  | action, key_valid, key_index, est_us, meas_us, escaped
//  m_axis  | out | seed_scale .. seeded_count, one beat per input beat
//
// Each accepted beat goes through the read and write states before its result beat;
// note_slice with positive estimate also runs the radix-2 ratio divider and the
// average update with its staged multiply by 1/5; reset_measurements adds a
// one-entry-a-cycle stats sweep over all KEY_ENTRIES entries.
// After rst a clearing pass initializes both memories.
// A stalled output beat holds the block; no new beat is taken meanwhile.
module slice_cost_registry_top #(
  parameter int KEY_ENTRIES = scr_pkg::KEY_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action[2:0], key_valid[3], key_index[9:4], est_us[41:10],
  // meas_us[73:42], escaped[74], zero fill to 80
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // seed_scale[24:0], scale_average_whole[49:25], last_slice_time[82:50],
  // worst_slice_time[114:83], second_worst_time[146:115],
  // total_slice_time[194:147], slice_total_count[226:195],
  // deferral_count[258:227], escape_count[290:259], seeded_count[322:291], fill to 328
  output logic [327:0] m_axis_tdata
);
  import scr_pkg::*;

  localparam int AW = (KEY_ENTRIES > 1) ? $clog2(KEY_ENTRIES) : 1;
  // ceil(2^43 / 5): exact floor(z / 5) for z below 2^42
  localparam logic [40:0] FIFTH_RCP = 41'h199_9999_999A;

  stats_t stats_mem [KEY_ENTRIES];
  learn_t learn_mem [KEY_ENTRIES];
  stats_t stats_rd;
  learn_t learn_rd;
  stats_t stats_wd;
  learn_t learn_wd;
  logic   stats_we, learn_we;
  logic [AW-1:0] waddr, raddr;

  state_t state, state_next;
  logic [AW:0]  sweep;
  logic         init_done;
  logic [2:0]   act;
  logic         live, in_range, esc;
  logic [AW-1:0] idx;
  logic [31:0]  est, meas;
  logic [6:0]   div_cnt;
  logic [64:0]  quo;
  logic [32:0]  rem;
  logic [40:0]  avg;
  logic [1:0]   mul_cnt;
  logic [39:0]  zq;
  logic [80:0]  acc;
  learn_t       learn_q;
  stats_t       stats_q;
  result_t      res;

  always_ff @(posedge clk) begin
    if (stats_we) stats_mem[waddr] <= stats_wd;
    if (learn_we) learn_mem[waddr] <= learn_wd;
    stats_rd <= stats_mem[raddr];
    learn_rd <= learn_mem[raddr];
  end

  logic [5:0]  key_in;
  logic        key_ok;
  logic [32:0] rem_sh;
  logic [35:0] sample;
  logic [40:0] diff, avg_new;
  logic [41:0] dif3;
  logic [19:0] m_a;
  logic [20:0] m_b;
  logic [40:0] prod;
  logic [80:0] prod_sh;
  logic [48:0] sum_w;

  always_comb begin
    key_in = s_axis_tdata[9:4];
    key_ok = {26'd0, key_in} < 32'(KEY_ENTRIES);
    raddr = AW'(key_in);
    rem_sh = {rem[31:0], quo[64]};
    sample = (quo > 65'(SAMPLE_MAX)) ? SAMPLE_MAX :
             (quo < 65'(AVG_ONE)) ? 36'(AVG_ONE) : quo[35:0];
    diff = (41'(sample) > avg) ? 41'(sample) - avg : avg - 41'(sample);
    dif3 = {diff, 1'b0} + {1'b0, diff};
    m_a = mul_cnt[1] ? zq[39:20] : zq[19:0];
    m_b = mul_cnt[0] ? FIFTH_RCP[40:20] : {1'b0, FIFTH_RCP[19:0]};
    prod = {21'd0, m_a} * {20'd0, m_b};
    case (mul_cnt)
      2'd0: prod_sh = {40'd0, prod};
      2'd3: prod_sh = {prod, 40'd0};
      default: prod_sh = {20'd0, prod, 20'd0};
    endcase
    avg_new = (41'(sample) > avg) ? avg + (diff >> 1) : avg - {3'd0, acc[80:43]};
    if (avg_new < AVG_ONE) avg_new = AVG_ONE;
    if (avg_new > AVG_MAX) avg_new = AVG_MAX;
    sum_w = {1'b0, stats_q.sum} + 49'(meas);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      sweep <= '0;
      init_done <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        sweep <= sweep + 1'b1;
        if (sweep == (AW+1)'(KEY_ENTRIES - 1)) init_done <= 1'b1;
      end else sweep <= '0;
      if (state == ST_OUT && !m_axis_tvalid) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      act  <= s_axis_tdata[2:0];
      in_range <= key_ok;
      live <= s_axis_tdata[3] && key_ok;
      idx  <= raddr;
      est  <= s_axis_tdata[41:10];
      meas <= s_axis_tdata[73:42];
      esc  <= s_axis_tdata[74];
    end
    case (state)
      ST_READ: begin
        learn_q <= learn_rd;
        stats_q <= stats_rd;
        avg <= learn_rd.avg;
        quo <= {1'b0, meas, 32'd0};
        rem <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        div_cnt <= div_cnt + 1'b1;
        if (rem_sh >= {1'b0, est}) begin
          rem <= rem_sh - {1'b0, est};
          quo <= {quo[63:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[63:0], 1'b0};
        end
      end
      ST_PREP: begin
        zq <= dif3[41:2];
        acc <= '0;
        mul_cnt <= '0;
      end
      ST_MUL: begin
        acc <= acc + prod_sh;
        mul_cnt <= mul_cnt + 1'b1;
      end
      ST_AVG: avg <= avg_new;
      ST_WRITE: begin
        res.seed_scale <= (act == ACT_SEED) ? (live ? learn_wd.last_seed : 25'd65536) : '0;
        res.scale_whole <= in_range ? learn_wd.avg[40:16] : 25'd65536;
        res.st <= in_range ? stats_wd : STATS_RESET;
        res.seeded <= in_range ? learn_wd.seeded : '0;
      end
      ST_CLEAR: if (init_done) res.st <= in_range ? STATS_RESET : STATS_RESET;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    s_axis_tready = 1'b0;
    stats_we = 1'b0;
    learn_we = 1'b0;
    waddr = idx;
    learn_wd = learn_q;
    learn_wd.avg = avg;
    stats_wd = stats_q;
    case (state)
      ST_IDLE: begin
        s_axis_tready = !m_axis_tvalid;
        if (s_axis_tvalid && s_axis_tready) state_next = ST_READ;
      end
      ST_READ: state_next = (act == ACT_SLICE && live && !est[31] && est != 0) ?
                            ST_DIV : ST_WRITE;
      ST_DIV: if (div_cnt == 7'd64) state_next = ST_PREP;
      ST_PREP: state_next = ST_MUL;
      ST_MUL: if (mul_cnt == 2'd3) state_next = ST_AVG;
      ST_AVG: state_next = ST_WRITE;
      ST_WRITE: begin
        if (live && act == ACT_SEED) begin
          learn_wd.seeded = (learn_q.seeded == '1) ? learn_q.seeded : learn_q.seeded + 1'b1;
          learn_wd.last_seed = avg[40:16];
        end
        if (live && act == ACT_SLICE) begin
          stats_wd.last_slice = {1'b0, meas};
          if (meas > stats_q.worst) begin
            stats_wd.second = stats_q.worst;
            stats_wd.worst = meas;
          end else if (meas > stats_q.second) stats_wd.second = meas;
          stats_wd.sum = sum_w[48] ? '1 : sum_w[47:0];
          stats_wd.slices = (stats_q.slices == '1) ? stats_q.slices : stats_q.slices + 1'b1;
        end
        if (live && act == ACT_DEFERRAL) begin
          if (esc) stats_wd.escapes = (stats_q.escapes == '1) ? stats_q.escapes
                                      : stats_q.escapes + 1'b1;
          else stats_wd.deferrals = (stats_q.deferrals == '1) ? stats_q.deferrals
                                    : stats_q.deferrals + 1'b1;
        end
        if (act == ACT_CLEAR) stats_wd = STATS_RESET;
        stats_we = live;
        learn_we = live;
        state_next = (act == ACT_CLEAR) ? ST_CLEAR : ST_OUT;
      end
      ST_CLEAR: begin
        waddr = sweep[AW-1:0];
        stats_we = 1'b1;
        stats_wd = STATS_RESET;
        learn_we = !init_done;
        learn_wd = LEARN_RESET;
        if (sweep == (AW+1)'(KEY_ENTRIES - 1)) state_next = init_done ? ST_OUT : ST_IDLE;
      end
      ST_OUT: if (!m_axis_tvalid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign m_axis_tdata = {5'd0, res.seeded, res.st.escapes, res.st.deferrals, res.st.slices,
                         res.st.sum, res.st.second, res.st.worst, res.st.last_slice,
                         res.scale_whole, res.seed_scale};

endmodule

// ===== rtl/core/scr_checker.sv =====
// Port-level checker for the slice cost registry, bound to the top level.
// Depends on scr_pkg.
module scr_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [327:0] m_axis_tdata
);
  import scr_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled beat changed");

  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");

  a_scale_floor: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[49:25] >= 25'd65536)
    else $error("scale below one");

  a_worst_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[114:83] >= m_axis_tdata[146:115])
    else $error("second worst above worst");

endmodule

bind slice_cost_registry_top scr_checker u_scr_checker (.*);

// ===== bench/tb_slice_cost_registry_top.sv =====
// Testbench for slice_cost_registry_top: drives action beats, predicts every result
// beat with an in-bench model of the per-key cost table, compares each whole beat and
// prints it field by field on a mismatch. Depends on scr_pkg and the block RTL.
`timescale 1ns / 100ps

module tb_slice_cost_registry_top;
  import scr_pkg::*;

  localparam int NKEY = 64;
  localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
  localparam logic [63:0] SMP_MAX = 64'h8_0000_0000;
  localparam logic [63:0] SCALE_MAX = 64'h100_0000_0000;
  localparam logic [31:0] M32 = 32'hFFFF_FFFF;
  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [327:0] m_axis_tdata;

  slice_cost_registry_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // per-entry table mirror
  logic [63:0] avg_q [NKEY];
  logic [31:0] seeds_n [NKEY];
  logic [32:0] last_t [NKEY];
  logic [31:0] worst_t [NKEY];
  logic [31:0] second_t [NKEY];
  logic [47:0] sum_t [NKEY];
  logic [31:0] slices_n [NKEY];
  logic [31:0] defer_n [NKEY];
  logic [31:0] escape_n [NKEY];

  logic [327:0] expected_beats [$];
  int mismatches = 0;
  int beats_checked = 0;
  int items_sent = 0;
  bit quiet_out = 1'b0;
  bit quiet_in = 1'b0;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == M32) ? M32 : v + 32'd1;
  endfunction

  function automatic void clear_stats_all();
    for (int k = 0; k < NKEY; k++) begin
      last_t[k] = '1;
      worst_t[k] = '0;
      second_t[k] = '0;
      sum_t[k] = '0;
      slices_n[k] = '0;
      defer_n[k] = '0;
      escape_n[k] = '0;
    end
  endfunction

  function automatic void table_reset();
    for (int k = 0; k < NKEY; k++) begin
      avg_q[k] = ONE_Q32;
      seeds_n[k] = '0;
    end
    clear_stats_all();
  endfunction

  function automatic void note_slice(int k, logic [31:0] est, logic [31:0] meas);
    logic [48:0] s;
    logic [63:0] smp;
    logic [63:0] a;
    last_t[k] = {1'b0, meas};
    if (meas > worst_t[k]) begin
      second_t[k] = worst_t[k];
      worst_t[k] = meas;
    end else if (meas > second_t[k]) begin
      second_t[k] = meas;
    end
    s = {1'b0, sum_t[k]} + {17'd0, meas};
    sum_t[k] = s[48] ? M48 : s[47:0];
    slices_n[k] = sat_inc(slices_n[k]);
    if (est[31] || est == 0) return;
    smp = {meas, 32'd0} / {32'd0, est};
    if (smp < ONE_Q32) smp = ONE_Q32;
    if (smp > SMP_MAX) smp = SMP_MAX;
    a = avg_q[k];
    if (smp > a) a = a + ((smp - a) >> 1);
    else a = a - ((a - smp) * 3) / 20;
    if (a < ONE_Q32) a = ONE_Q32;
    if (a > SCALE_MAX) a = SCALE_MAX;
    avg_q[k] = a;
  endfunction

  function automatic logic [327:0] registry_result(logic [2:0] act, bit kv, int k,
                                                   logic [31:0] est, logic [31:0] meas,
                                                   bit esc);
    logic [24:0] seed;
    seed = '0;
    case (act)
      ACT_SEED: begin
        if (kv) begin
          seeds_n[k] = sat_inc(seeds_n[k]);
          seed = avg_q[k][40:16];
        end else begin
          seed = 25'd65536;
        end
      end
      ACT_SLICE: if (kv) note_slice(k, est, meas);
      ACT_DEFERRAL: begin
        if (kv) begin
          if (esc) escape_n[k] = sat_inc(escape_n[k]);
          else defer_n[k] = sat_inc(defer_n[k]);
        end
      end
      ACT_CLEAR: clear_stats_all();
      default: ;
    endcase
    return {5'd0, seeds_n[k], escape_n[k], defer_n[k], slices_n[k], sum_t[k], second_t[k],
            worst_t[k], last_t[k], avg_q[k][40:16], seed};
  endfunction

  task automatic send_beat(logic [2:0] act, bit kv, int k, logic [31:0] est,
                           logic [31:0] meas, bit esc);
    while (!quiet_in && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata <= {5'd0, esc, meas, est, k[5:0], kv, act};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_beats.insert(expected_beats.size(), registry_result(act, kv, k, est, meas, esc));
    items_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) m_axis_tready <= quiet_out || ($urandom_range(99) >= 34);

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      logic [327:0] exp_beat;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        exp_beat = expected_beats.pop_front();
        beats_checked++;
        if (exp_beat !== m_axis_tdata) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on beat %0d", beats_checked);
            $display("  seed exp %0d act %0d, scale exp %0d act %0d",
                     exp_beat[24:0], m_axis_tdata[24:0], exp_beat[49:25], m_axis_tdata[49:25]);
            $display("  last exp %h act %h, worst exp %h act %h, second exp %h act %h",
                     exp_beat[82:50], m_axis_tdata[82:50], exp_beat[114:83],
                     m_axis_tdata[114:83], exp_beat[146:115], m_axis_tdata[146:115]);
            $display("  sum exp %h act %h, counts exp %h act %h",
                     exp_beat[194:147], m_axis_tdata[194:147], exp_beat[322:195],
                     m_axis_tdata[322:195]);
          end
        end
      end
    end
  end

  function automatic logic [31:0] rand_est();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return $urandom | 32'h8000_0000;
      2: return $urandom;
      default: return $urandom_range(4000, 1);
    endcase
  endfunction

  task automatic test_directed();
    send_beat(ACT_READ, 1, 0, 0, 0, 0);
    send_beat(ACT_SEED, 0, 5, 0, 0, 0);
    send_beat(ACT_SEED, 1, 5, 0, 0, 0);
    send_beat(ACT_SLICE, 1, 5, 100, 800, 0);
    send_beat(ACT_SLICE, 1, 5, 100, M32, 0);
    send_beat(ACT_SLICE, 1, 5, 32'h7FFF_FFFF, 0, 0);
    send_beat(ACT_SLICE, 1, 5, 0, 500, 0);
    send_beat(ACT_SLICE, 1, 5, 32'h8000_0000, 600, 0);
    send_beat(ACT_SLICE, 1, 5, M32, 700, 0);
    send_beat(ACT_SLICE, 1, 5, 1, M32, 0);
    send_beat(ACT_SLICE, 0, 5, 1, 999, 0);
    send_beat(ACT_SEED, 1, 5, 0, 0, 0);
    send_beat(ACT_DEFERRAL, 1, 63, 0, 0, 0);
    send_beat(ACT_DEFERRAL, 1, 63, 0, 0, 1);
    send_beat(ACT_DEFERRAL, 0, 63, 0, 0, 1);
    send_beat(3'd5, 1, 5, M32, M32, 1);
    send_beat(3'd6, 1, 5, 0, 0, 0);
    send_beat(3'd7, 0, 63, 0, 0, 0);
    send_beat(ACT_CLEAR, 0, 63, M32, M32, 1);
    send_beat(ACT_READ, 1, 5, 0, 0, 0);
    send_beat(ACT_SLICE, 1, 5, 1, 0, 0);
  endtask

  task automatic test_saturation();
    for (int i = 0; i < 20; i++) send_beat(ACT_SLICE, 1, 9, 0, M32, 0);
  endtask

  task automatic test_random(int n);
    logic [2:0] act;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) act = ACT_SLICE;
      else if (r < 65) act = ACT_SEED;
      else if (r < 80) act = ACT_DEFERRAL;
      else if (r < 83) act = ACT_CLEAR;
      else if (r < 95) act = ACT_READ;
      else act = 3'($urandom_range(7, 5));
      quiet_in = (i >= n / 2 && i < n / 2 + 150);
      quiet_out = quiet_in;
      send_beat(act, $urandom_range(9) != 0,
                ($urandom_range(1) ? $urandom_range(7) : $urandom_range(63)),
                rand_est(),
                ($urandom_range(3) == 0 ? $urandom : $urandom_range(20000)),
                $urandom_range(1));
    end
    quiet_in = 0;
    quiet_out = 0;
  endtask

  initial begin
    table_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_saturation();
    test_random(1060);
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d beats over all actions, empty keys, clears and ratio clamps",
             items_sent);
    if (mismatches == 0 && expected_beats.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
